// ===== rtl/psw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package psw_pkg;

  localparam int COORD_W = 24;
  localparam int TIME_W  = 32;
  localparam int PRESS_W = 16;
  localparam int WIDTH_W = 16;
  localparam int SPREAD_W = 9;
  localparam int ADIFF_W = COORD_W + 1;
  localparam int D2_W    = 2 * ADIFF_W;
  localparam int ROOT_W  = ADIFF_W;
  localparam int DIV_W   = 40;
  localparam int DVS_W   = 32;
  localparam int TGT_W   = 25;
  localparam int SMW_W   = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [WIDTH_W-1:0]  BASE_RESET    = 16'd361;
  localparam logic [SPREAD_W-1:0] SPREAD_RESET  = 9'd141;
  localparam logic [WIDTH_W-1:0]  MINSTEP_RESET = 16'd205;
  localparam logic [PRESS_W:0]    PRESS_MARGIN  = 17'd1310;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SPREAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = 3'd4;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_START = 5'd1;
  localparam logic [4:0] OP_LOAD  = 5'd2;
  localparam logic [4:0] OP_END   = 5'd3;
  localparam logic [4:0] OP_SQX   = 5'd4;
  localparam logic [4:0] OP_SQY   = 5'd5;
  localparam logic [4:0] OP_TRACK = 5'd6;
  localparam logic [4:0] OP_NDIV  = 5'd7;
  localparam logic [4:0] OP_PTMUL = 5'd8;
  localparam logic [4:0] OP_PTDIV = 5'd9;
  localparam logic [4:0] OP_TQ    = 5'd10;
  localparam logic [4:0] OP_SQRT  = 5'd11;
  localparam logic [4:0] OP_SDIV  = 5'd12;
  localparam logic [4:0] OP_SRED  = 5'd13;
  localparam logic [4:0] OP_STGT  = 5'd14;
  localparam logic [4:0] OP_TBASE = 5'd15;
  localparam logic [4:0] OP_SMDIV = 5'd16;
  localparam logic [4:0] OP_SMFIN = 5'd17;

  typedef struct packed {
    logic [4:0] op;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic stroke_active;
    logic too_short;
    logic press_use;
    logic speed_en;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/psw_div.sv =====
// Restoring divider, one quotient bit per cycle.
module psw_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psw_pkg::DIV_W-1:0]   dividend,
  input  logic [psw_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [psw_pkg::DIV_W-1:0]   quotient
);
  localparam int CNT_W = $clog2(psw_pkg::DIV_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [psw_pkg::DIV_W-1:0]   q_r, q_nxt;
  logic [psw_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [psw_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [psw_pkg::DVS_W:0]     rem_sh;
  logic                        ge;

  assign rem_sh = {rem_r, q_r[psw_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(psw_pkg::DIV_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[psw_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? psw_pkg::DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[psw_pkg::DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// ===== rtl/psw_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module psw_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psw_pkg::D2_W-1:0]    radicand,
  output logic                        done,
  output logic [psw_pkg::ROOT_W-1:0]  root
);
  localparam int CNT_W = $clog2(psw_pkg::ROOT_W + 1);
  localparam int REM_W = psw_pkg::ROOT_W + 3;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [psw_pkg::D2_W-1:0]    op_r, op_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [psw_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]            rem_sh, trial;
  logic                        ge;

  assign rem_sh = {rem_r[REM_W-3:0], op_r[psw_pkg::D2_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(psw_pkg::ROOT_W);
      op_nxt   = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      op_nxt   = {op_r[psw_pkg::D2_W-3:0], 2'b00};
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_r[psw_pkg::ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r   <= op_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ===== rtl/psw_dp.sv =====
// Datapath: configuration, stroke state, arithmetic and the output register.
module psw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psw_pkg::cmd_t                       cmd,
  output psw_pkg::status_t                    status,
  input  logic signed [psw_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [psw_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [psw_pkg::PRESS_W-1:0]         in_pen_pressure,
  input  logic [psw_pkg::TIME_W-1:0]          in_time_ms,
  input  logic                                cfg_we,
  input  logic [psw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psw_pkg::WIDTH_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psw_pkg::COORD_W-1:0]  out_point_x,
  output logic signed [psw_pkg::COORD_W-1:0]  out_point_y,
  output logic [psw_pkg::WIDTH_W-1:0]         out_point_width,
  output logic                                out_first_point
);
  localparam int CW = psw_pkg::COORD_W;
  localparam int AW = psw_pkg::ADIFF_W;
  localparam int NQ_W = 17;
  localparam logic [NQ_W-1:0] NORM_MAX = 17'd65536;

  // constant divides: a / 1280 as (a >> 8) / 5, a / 100 as (a >> 2) / 25,
  // each by a reciprocal multiply and one correcting compare and subtract
  localparam int CX_W     = 30;
  localparam int CP_W     = 2 * CX_W;
  localparam int CQ_W     = 28;
  localparam int RECIP_SH = 32;
  localparam logic [CX_W-1:0] RECIP_5  = 30'd858993459;  // floor(2^32 / 5)
  localparam logic [CX_W-1:0] RECIP_25 = 30'd171798691;  // floor(2^32 / 25)

  // configuration
  logic [psw_pkg::WIDTH_W-1:0]  base_r;
  logic                         speed_en_r;
  logic [psw_pkg::SPREAD_W-1:0] spread_r;
  logic                         press_en_r;
  logic [psw_pkg::WIDTH_W-1:0]  min_step_r;

  // stroke state
  logic                          active_r;
  logic signed [CW-1:0]          last_x_r, last_y_r, cur_x_r, cur_y_r;
  logic [psw_pkg::TIME_W-1:0]    last_t_r, cur_t_r;
  logic [psw_pkg::PRESS_W-1:0]   cur_p_r, plow_r, phigh_r;
  logic [psw_pkg::SMW_W-1:0]     smw_r;

  // work registers
  logic [psw_pkg::D2_W-1:0]      prod_r, d2_r;
  logic [2*psw_pkg::WIDTH_W-1:0] md2_r;
  logic [psw_pkg::TGT_W-1:0]     tgt_r;
  logic [25:0]                   red_r;

  // constant divide unit
  logic [CX_W-1:0]               cx_r;
  logic                          csel_r;
  logic [2:0]                    cstage_r;
  logic [CP_W-1:0]               cprod_r;
  logic [CQ_W-1:0]               cq0_r, cq_r;
  logic                          cdone_r;

  // result and output registers
  logic signed [CW-1:0]          res_x_r, res_y_r, ox_r, oy_r;
  logic [psw_pkg::WIDTH_W-1:0]   res_w_r, ow_r;
  logic                          res_first_r, of_r, ov_r;

  logic signed [AW-1:0]          dx, dy;
  logic [AW-1:0]                 ax, ay;
  logic [psw_pkg::D2_W-1:0]      ax_sq, ay_sq;
  logic                          p_ok, cur_p_ok;
  logic [NQ_W-1:0]               nq;
  logic                          div_start, div_done, sqrt_done;
  logic [psw_pkg::DIV_W-1:0]     div_a, div_q;
  logic [psw_pkg::DVS_W-1:0]     div_b;
  logic                          cdiv_start, cdiv_sel;
  logic [CX_W-1:0]               cdiv_a, crecip, cq0_mul, crem, cstep;
  logic [psw_pkg::DIV_W-1:0]     sm_sum;
  logic [psw_pkg::ROOT_W-1:0]    root;
  logic [psw_pkg::TIME_W-1:0]    dt;
  logic [psw_pkg::SMW_W:0]       w_round;
  logic [16:0]                   w_full;
  logic [psw_pkg::SMW_W-1:0]     smw_new;

  assign dx = AW'(cur_x_r) - AW'(last_x_r);
  assign dy = AW'(cur_y_r) - AW'(last_y_r);
  assign ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
  assign ay = dy[AW-1] ? AW'(-dy) : AW'(dy);
  assign ax_sq = {{AW{1'b0}}, ax} * {{AW{1'b0}}, ax};
  assign ay_sq = {{AW{1'b0}}, ay} * {{AW{1'b0}}, ay};

  assign p_ok     = (in_pen_pressure != '0) && (in_pen_pressure != '1);
  assign cur_p_ok = (cur_p_r != '0) && (cur_p_r != '1);
  assign nq = (div_q > psw_pkg::DIV_W'(NORM_MAX)) ? NORM_MAX : div_q[NQ_W-1:0];
  assign dt = (cur_t_r - last_t_r == '0) ? psw_pkg::TIME_W'(1) : cur_t_r - last_t_r;

  assign sm_sum = psw_pkg::DIV_W'(smw_r) * psw_pkg::DIV_W'(65)
                + psw_pkg::DIV_W'(tgt_r) * psw_pkg::DIV_W'(35) + psw_pkg::DIV_W'(50);

  // divider operand select
  always_comb begin
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    cdiv_start = 1'b0;
    cdiv_a     = '0;
    cdiv_sel   = 1'b0;
    unique case (cmd.op)
      psw_pkg::OP_NDIV: begin
        div_start = 1'b1;
        div_a = psw_pkg::DIV_W'({cur_p_r - plow_r, 16'h0000});
        div_b = psw_pkg::DVS_W'(phigh_r - plow_r);
      end
      psw_pkg::OP_PTDIV: begin
        cdiv_start = 1'b1;
        cdiv_a     = prod_r[8 +: CX_W];
        cdiv_sel   = 1'b0;
      end
      psw_pkg::OP_SDIV: begin
        div_start = 1'b1;
        div_a = psw_pkg::DIV_W'({root, 7'b0}) + psw_pkg::DIV_W'({root, 5'b0});
        div_b = psw_pkg::DVS_W'(dt);
      end
      psw_pkg::OP_SMDIV: begin
        cdiv_start = 1'b1;
        cdiv_a     = sm_sum[2 +: CX_W];
        cdiv_sel   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  psw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  psw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == psw_pkg::OP_SQRT),
    .radicand (d2_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // reciprocal estimate is exact or one low; one compare fixes it
  assign crecip  = csel_r ? RECIP_25 : RECIP_5;
  assign cstep   = csel_r ? CX_W'(25) : CX_W'(5);
  assign cq0_mul = CX_W'(cq0_r) * cstep;
  assign crem    = cx_r - cq0_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cstage_r <= '0;
      cdone_r  <= 1'b0;
    end else begin
      cstage_r <= {cstage_r[1:0], cdiv_start};
      cdone_r  <= cstage_r[2];
    end
    if (cdiv_start) begin
      cx_r   <= cdiv_a;
      csel_r <= cdiv_sel;
    end
    cprod_r <= CP_W'(cx_r) * CP_W'(crecip);
    cq0_r   <= cprod_r[RECIP_SH +: CQ_W];
    cq_r    <= (crem >= cstep) ? cq0_r + CQ_W'(1) : cq0_r;
  end

  assign smw_new = cq_r[psw_pkg::SMW_W-1:0];
  assign w_round = {1'b0, smw_new} + (psw_pkg::SMW_W + 1)'(128);
  assign w_full  = w_round[psw_pkg::SMW_W:8];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= psw_pkg::BASE_RESET;
      speed_en_r <= 1'b1;
      spread_r   <= psw_pkg::SPREAD_RESET;
      press_en_r <= 1'b1;
      min_step_r <= psw_pkg::MINSTEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psw_pkg::REG_BASE_WIDTH:   base_r     <= cfg_data;
        psw_pkg::REG_SPEED_EN:     speed_en_r <= cfg_data[0];
        psw_pkg::REG_WIDTH_SPREAD: spread_r   <= cfg_data[psw_pkg::SPREAD_W-1:0];
        psw_pkg::REG_PRESSURE_EN:  press_en_r <= cfg_data[0];
        psw_pkg::REG_MIN_STEP:     min_step_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stroke state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      last_t_r <= '0;
      smw_r    <= psw_pkg::SMW_W'({psw_pkg::BASE_RESET, 8'h00});
      plow_r   <= '1;
      phigh_r  <= '0;
    end else begin
      unique case (cmd.op)
        psw_pkg::OP_START: begin
          active_r <= 1'b1;
          last_x_r <= in_pos_x;
          last_y_r <= in_pos_y;
          last_t_r <= in_time_ms;
          smw_r    <= {base_r, 8'h00};
          if (p_ok && in_pen_pressure < plow_r)  plow_r  <= in_pen_pressure;
          if (p_ok && in_pen_pressure > phigh_r) phigh_r <= in_pen_pressure;
        end
        psw_pkg::OP_END: active_r <= 1'b0;
        psw_pkg::OP_TRACK: begin
          if (cur_p_ok && cur_p_r < plow_r)  plow_r  <= cur_p_r;
          if (cur_p_ok && cur_p_r > phigh_r) phigh_r <= cur_p_r;
        end
        psw_pkg::OP_SMFIN: begin
          smw_r    <= smw_new;
          last_x_r <= cur_x_r;
          last_y_r <= cur_y_r;
          last_t_r <= cur_t_r;
        end
        default: begin
        end
      endcase
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      psw_pkg::OP_START: begin
        res_x_r     <= in_pos_x;
        res_y_r     <= in_pos_y;
        res_w_r     <= base_r;
        res_first_r <= 1'b1;
      end
      psw_pkg::OP_LOAD: begin
        cur_x_r <= in_pos_x;
        cur_y_r <= in_pos_y;
        cur_p_r <= in_pen_pressure;
        cur_t_r <= in_time_ms;
      end
      psw_pkg::OP_SQX: begin
        prod_r <= ax_sq;
        md2_r  <= {16'h0000, min_step_r} * {16'h0000, min_step_r};
      end
      psw_pkg::OP_SQY:   d2_r <= prod_r + ay_sq;
      psw_pkg::OP_PTMUL: prod_r <= psw_pkg::D2_W'(
          {19'b0, base_r} * (35'd131072 + 35'(nq) * 35'd3) + 35'd640);
      psw_pkg::OP_TQ:    tgt_r <= cq_r[psw_pkg::TGT_W-1:0];
      psw_pkg::OP_SRED:  red_r <= 26'(spread_r) * 26'(nq);
      psw_pkg::OP_STGT: begin
        if (red_r >= 26'd16777216) tgt_r <= '0;
        else tgt_r <= psw_pkg::TGT_W'(
            ({25'b0, base_r} * (41'd16777216 - 41'(red_r))) >> 16);
      end
      psw_pkg::OP_TBASE: tgt_r <= psw_pkg::TGT_W'({base_r, 8'h00});
      psw_pkg::OP_SMFIN: begin
        res_x_r     <= cur_x_r;
        res_y_r     <= cur_y_r;
        res_w_r     <= w_full[16] ? 16'hFFFF : w_full[15:0];
        res_first_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (cmd.emit) begin
      ox_r <= res_x_r;
      oy_r <= res_y_r;
      ow_r <= res_w_r;
      of_r <= res_first_r;
    end
  end

  assign status.stroke_active = active_r;
  assign status.too_short     = d2_r < psw_pkg::D2_W'(md2_r);
  assign status.press_use     = press_en_r && cur_p_ok &&
                                ({1'b0, phigh_r} > {1'b0, plow_r} + psw_pkg::PRESS_MARGIN);
  assign status.speed_en      = speed_en_r;
  assign status.div_done      = div_done | cdone_r;
  assign status.sqrt_done     = sqrt_done;
  assign status.out_free      = !ov_r || !out_stall;

  assign out_valid       = ov_r;
  assign out_point_x     = ox_r;
  assign out_point_y     = oy_r;
  assign out_point_width = ow_r;
  assign out_first_point = of_r;
endmodule

// ===== rtl/psw_ctrl.sv =====
// Controller: sequences one sample through the datapath.
module psw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_req_type,
  output logic              in_stall,
  input  psw_pkg::status_t  status,
  output psw_pkg::cmd_t     cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQX    = 4'd1;
  localparam logic [3:0] S_SQY    = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_SEL    = 4'd4;
  localparam logic [3:0] S_NWAIT  = 4'd5;
  localparam logic [3:0] S_PTMUL  = 4'd6;
  localparam logic [3:0] S_PTWAIT = 4'd7;
  localparam logic [3:0] S_SQWAIT = 4'd8;
  localparam logic [3:0] S_SDWAIT = 4'd9;
  localparam logic [3:0] S_STGT   = 4'd10;
  localparam logic [3:0] S_SMST   = 4'd11;
  localparam logic [3:0] S_SMWAIT = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = psw_pkg::OP_NONE;
    cmd.emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_req_type == psw_pkg::REQ_START) begin
            cmd.op    = psw_pkg::OP_START;
            state_nxt = S_EMIT;
          end else if (in_req_type == psw_pkg::REQ_MOVE && status.stroke_active) begin
            cmd.op    = psw_pkg::OP_LOAD;
            state_nxt = S_SQX;
          end else if (in_req_type == psw_pkg::REQ_END) begin
            cmd.op = psw_pkg::OP_END;
          end else begin
          end
        end
      end
      S_SQX: begin
        cmd.op    = psw_pkg::OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = psw_pkg::OP_SQY;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (status.too_short) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = psw_pkg::OP_TRACK;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        priority if (status.press_use) begin
          cmd.op    = psw_pkg::OP_NDIV;
          state_nxt = S_NWAIT;
        end else if (status.speed_en) begin
          cmd.op    = psw_pkg::OP_SQRT;
          state_nxt = S_SQWAIT;
        end else begin
          cmd.op    = psw_pkg::OP_TBASE;
          state_nxt = S_SMST;
        end
      end
      S_NWAIT: begin
        if (status.div_done) begin
          cmd.op    = psw_pkg::OP_PTMUL;
          state_nxt = S_PTMUL;
        end
      end
      S_PTMUL: begin
        cmd.op    = psw_pkg::OP_PTDIV;
        state_nxt = S_PTWAIT;
      end
      S_PTWAIT: begin
        if (status.div_done) begin
          cmd.op    = psw_pkg::OP_TQ;
          state_nxt = S_SMST;
        end
      end
      S_SQWAIT: begin
        if (status.sqrt_done) begin
          cmd.op    = psw_pkg::OP_SDIV;
          state_nxt = S_SDWAIT;
        end
      end
      S_SDWAIT: begin
        if (status.div_done) begin
          cmd.op    = psw_pkg::OP_SRED;
          state_nxt = S_STGT;
        end
      end
      S_STGT: begin
        cmd.op    = psw_pkg::OP_STGT;
        state_nxt = S_SMST;
      end
      S_SMST: begin
        cmd.op    = psw_pkg::OP_SMDIV;
        state_nxt = S_SMWAIT;
      end
      S_SMWAIT: begin
        if (status.div_done) begin
          cmd.op    = psw_pkg::OP_SMFIN;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("point loaded while output register still held");

  a_move_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && status.too_short) |=> state_r == S_IDLE)
    else $error("short move did not return to idle");

  a_emit_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == psw_pkg::OP_START) |=> state_r == S_EMIT)
    else $error("stroke start did not head for emit");
endmodule

// ===== rtl/pen_stroke_width_shaper.sv =====
// Top level of the pen stroke width shaper.
// Turns pen samples into stroke points with a width. A start beat opens a
// stroke and gives one point at base_width with first_point set; an end beat
// closes the stroke and gives nothing. A move beat gives a point only while a
// stroke is open and the pen has moved at least min_step_distance; its width
// target comes from normalized pressure when pressure use is enabled, the
// sample's pressure is valid and the tracked pressure range is wide enough,
// else from pen speed (when enabled), else from base_width, and is smoothed
// exponentially. One sample is worked on at a time. A move that emits runs
// a reciprocal divide for smoothing; with a fixed target that is all, with a
// pressure target it first takes one pass of the shared one-bit-per-cycle
// divider plus a second reciprocal divide, and with a speed target a square
// root and a divider pass. A stall on the result channel holds the block
// only while a finished point waits for the output register to free up; a
// finished point waits in the output register while the next beat is taken.
// Configuration writes are always taken (cfg_ready is tied high) and should
// only be made while the block is idle.
module pen_stroke_width_shaper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic signed [psw_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [psw_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [psw_pkg::PRESS_W-1:0]         in_pen_pressure,
  input  logic [psw_pkg::TIME_W-1:0]          in_time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psw_pkg::COORD_W-1:0]  out_point_x,
  output logic signed [psw_pkg::COORD_W-1:0]  out_point_y,
  output logic [psw_pkg::WIDTH_W-1:0]         out_point_width,
  output logic                                out_first_point,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psw_pkg::WIDTH_W-1:0]         cfg_data
);
  psw_pkg::cmd_t    cmd;
  psw_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // Sequence each accepted beat.
  psw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Hold state, do the arithmetic, and drive the result channel.
  psw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pen_pressure (in_pen_pressure),
    .in_time_ms      (in_time_ms),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_width (out_point_width),
    .out_first_point (out_first_point)
  );
endmodule
